// ===== design/bbo_pkg.sv =====
// ----------------------------------------------------------------------------
// bbo_pkg
// Shared widths, item codes, register indexes and types of the box overlay.
// ----------------------------------------------------------------------------
package bbo_pkg;

   localparam int MAX_BOXES_DEFAULT = 16;
   localparam int BAND_W_DEFAULT    = 2;

   localparam int KIND_W   = 2;
   localparam int SLOT_W   = 4;
   localparam int CORNER_W = 13;
   localparam int PIX_W    = 12;
   localparam int COLOR_W  = 8;
   localparam int DIM_W    = 13;
   // signed width of clamped corners and band bounds (covers -8192 .. 8191)
   localparam int BND_W    = 14;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd2;

   localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_COLOR_R      = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_COLOR_G      = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_COLOR_B      = 3'd4;

   localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RST  = 13'd640;
   localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RST = 13'd480;
   localparam logic [COLOR_W-1:0] COLOR_R_RST      = 8'd255;
   localparam logic [COLOR_W-1:0] COLOR_G_RST      = 8'd255;
   localparam logic [COLOR_W-1:0] COLOR_B_RST      = 8'd0;

   typedef logic signed [BND_W-1:0] bnd_type;

   // precomputed band bounds of one box; every test is then a plain compare
   typedef struct packed {
      bnd_type x0;
      bnd_type x0_end;
      bnd_type x1_start;
      bnd_type x1;
      bnd_type y0;
      bnd_type y0_end;
      bnd_type y1_start;
      bnd_type y1;
   } bounds_type;

   typedef struct packed {
      logic clear;
      logic load;
   } lane_ctl_type;

endpackage

// ===== design/bbo_req_if.sv =====
// ----------------------------------------------------------------------------
// bbo_req_if
// Input item channel: clear, box load or pixel, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bbo_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [bbo_pkg::KIND_W-1:0]           kind;
   logic [bbo_pkg::SLOT_W-1:0]           box_index;
   logic signed [bbo_pkg::CORNER_W-1:0]  box_left;
   logic signed [bbo_pkg::CORNER_W-1:0]  box_top;
   logic signed [bbo_pkg::CORNER_W-1:0]  box_right;
   logic signed [bbo_pkg::CORNER_W-1:0]  box_bottom;
   logic [bbo_pkg::PIX_W-1:0]            pixel_x;
   logic [bbo_pkg::PIX_W-1:0]            pixel_y;
   logic [bbo_pkg::COLOR_W-1:0]          in_r;
   logic [bbo_pkg::COLOR_W-1:0]          in_g;
   logic [bbo_pkg::COLOR_W-1:0]          in_b;

   modport source (
      output valid, kind, box_index, box_left, box_top, box_right, box_bottom,
             pixel_x, pixel_y, in_r, in_g, in_b,
      input  ready
   );
   modport sink (
      input  valid, kind, box_index, box_left, box_top, box_right, box_bottom,
             pixel_x, pixel_y, in_r, in_g, in_b,
      output ready
   );
endinterface

// ===== design/bbo_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bbo_rsp_if
// Result item channel: outgoing pixel color and border flag.
// ----------------------------------------------------------------------------
interface bbo_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bbo_pkg::COLOR_W-1:0] out_r;
   logic [bbo_pkg::COLOR_W-1:0] out_g;
   logic [bbo_pkg::COLOR_W-1:0] out_b;
   logic                        on_border;

   modport source (output valid, out_r, out_g, out_b, on_border, input ready);
   modport sink   (input  valid, out_r, out_g, out_b, on_border, output ready);
endinterface

// ===== design/bbo_box_lane.sv =====
// ----------------------------------------------------------------------------
// bbo_box_lane
// One box table slot: stored band bounds, valid bit and the border hit test.
// ----------------------------------------------------------------------------
module bbo_box_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  bbo_pkg::lane_ctl_type ctl,
   input  bbo_pkg::bounds_type   wr_bounds,
   input  bbo_pkg::bnd_type      pix_x,
   input  bbo_pkg::bnd_type      pix_y,
   output logic                  hit
);

   logic                valid_ff, valid_in;
   bbo_pkg::bounds_type entry_ff, entry_in;
   logic                rows, cols, left_band, right_band, top_band, bottom_band;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.load) begin
         valid_in = 1'b1;
      end
      entry_in = ctl.load ? wr_bounds : entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // table contents are undefined until loaded
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_comb begin
      rows        = (pix_y >= entry_ff.y0) && (pix_y < entry_ff.y1);
      cols        = (pix_x >= entry_ff.x0) && (pix_x < entry_ff.x1);
      left_band   = (pix_x >= entry_ff.x0) && (pix_x < entry_ff.x0_end);
      right_band  = (pix_x >= entry_ff.x1_start) && (pix_x < entry_ff.x1);
      top_band    = (pix_y >= entry_ff.y0) && (pix_y < entry_ff.y0_end);
      bottom_band = (pix_y >= entry_ff.y1_start) && (pix_y < entry_ff.y1);
      hit = valid_ff && ((rows && (left_band || right_band)) ||
                         (cols && (top_band || bottom_band)));
   end

endmodule

// ===== design/bounding_box_border_overlay_core.sv =====
// ----------------------------------------------------------------------------
// bounding_box_border_overlay_core
// Paints the outlines of up to MAX_BOXES boxes onto an RGB pixel stream.
// ----------------------------------------------------------------------------
// Takes one item per clock while input ready is high and returns a result per
// pixel item; clear and box-load items produce no result. The work runs in
// a three-stage pipeline: stage one clamps box corners into the image or
// checks a pixel against the image size, stage two writes the box table (one
// register lane per slot) or tests the pixel against all lanes at once, and
// stage three is the output register. Table writes and pixel tests happen in
// the same stage, so every pixel sees exactly the boxes loaded before it.
// Input ready drops only while all three stages are full and the result is
// not being taken. Registers may be written only while no item is in flight.
// ----------------------------------------------------------------------------
module bounding_box_border_overlay_core #(
   parameter int MAX_BOXES = bbo_pkg::MAX_BOXES_DEFAULT,
   parameter int BAND_W    = bbo_pkg::BAND_W_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   bbo_req_if.sink                          req,
   bbo_rsp_if.source                        rsp,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bbo_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bbo_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bbo_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   typedef struct packed {
      logic [bbo_pkg::KIND_W-1:0]          kind;
      logic [bbo_pkg::SLOT_W-1:0]          slot;
      logic signed [bbo_pkg::CORNER_W-1:0] left;
      logic signed [bbo_pkg::CORNER_W-1:0] top;
      logic signed [bbo_pkg::CORNER_W-1:0] right;
      logic signed [bbo_pkg::CORNER_W-1:0] bottom;
      logic [bbo_pkg::PIX_W-1:0]           x;
      logic [bbo_pkg::PIX_W-1:0]           y;
      logic [bbo_pkg::COLOR_W-1:0]         r;
      logic [bbo_pkg::COLOR_W-1:0]         g;
      logic [bbo_pkg::COLOR_W-1:0]         b;
   } s1_item_type;

   typedef struct packed {
      logic [bbo_pkg::KIND_W-1:0]  kind;
      logic [bbo_pkg::SLOT_W-1:0]  slot;
      bbo_pkg::bnd_type            x0;
      bbo_pkg::bnd_type            y0;
      bbo_pkg::bnd_type            x1;
      bbo_pkg::bnd_type            y1;
      logic [bbo_pkg::PIX_W-1:0]   x;
      logic [bbo_pkg::PIX_W-1:0]   y;
      logic                        in_image;
      logic [bbo_pkg::COLOR_W-1:0] r;
      logic [bbo_pkg::COLOR_W-1:0] g;
      logic [bbo_pkg::COLOR_W-1:0] b;
   } s2_item_type;

   typedef struct packed {
      logic [bbo_pkg::COLOR_W-1:0] r;
      logic [bbo_pkg::COLOR_W-1:0] g;
      logic [bbo_pkg::COLOR_W-1:0] b;
      logic                        on_border;
   } s3_item_type;

   // clamp v into [0, limit-1]; a zero limit gives 0
   function automatic bbo_pkg::bnd_type clamp_coord(
      input bbo_pkg::bnd_type              v,
      input logic [bbo_pkg::DIM_W-1:0]     limit
   );
      logic signed [bbo_pkg::BND_W:0] hi;
      logic signed [bbo_pkg::BND_W:0] vv;
      logic signed [bbo_pkg::BND_W:0] res;
      hi  = $signed((bbo_pkg::BND_W + 1)'(limit)) - $signed((bbo_pkg::BND_W + 1)'(1));
      vv  = (bbo_pkg::BND_W + 1)'(v);
      res = (vv > hi) ? hi : vv;
      if (res < 0) begin
         res = '0;
      end
      return bbo_pkg::bnd_type'(res[bbo_pkg::BND_W-1:0]);
   endfunction

   // configuration registers
   logic [bbo_pkg::DIM_W-1:0]   width_ff, width_in;
   logic [bbo_pkg::DIM_W-1:0]   height_ff, height_in;
   logic [bbo_pkg::COLOR_W-1:0] color_r_ff, color_r_in;
   logic [bbo_pkg::COLOR_W-1:0] color_g_ff, color_g_in;
   logic [bbo_pkg::COLOR_W-1:0] color_b_ff, color_b_in;
   logic                        csr_wr;
   logic [bbo_pkg::REG_IDX_W-1:0] csr_idx;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[bbo_pkg::CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      color_r_in = color_r_ff;
      color_g_in = color_g_ff;
      color_b_in = color_b_ff;
      if (csr_wr) begin
         case (csr_idx)
            bbo_pkg::REG_IMAGE_WIDTH:  width_in   = csr_pwdata[bbo_pkg::DIM_W-1:0];
            bbo_pkg::REG_IMAGE_HEIGHT: height_in  = csr_pwdata[bbo_pkg::DIM_W-1:0];
            bbo_pkg::REG_COLOR_R:      color_r_in = csr_pwdata[bbo_pkg::COLOR_W-1:0];
            bbo_pkg::REG_COLOR_G:      color_g_in = csr_pwdata[bbo_pkg::COLOR_W-1:0];
            bbo_pkg::REG_COLOR_B:      color_b_in = csr_pwdata[bbo_pkg::COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= bbo_pkg::IMAGE_WIDTH_RST;
         height_ff  <= bbo_pkg::IMAGE_HEIGHT_RST;
         color_r_ff <= bbo_pkg::COLOR_R_RST;
         color_g_ff <= bbo_pkg::COLOR_G_RST;
         color_b_ff <= bbo_pkg::COLOR_B_RST;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         color_r_ff <= color_r_in;
         color_g_ff <= color_g_in;
         color_b_ff <= color_b_in;
      end
   end

   always_comb begin
      case (csr_idx)
         bbo_pkg::REG_IMAGE_WIDTH:  csr_prdata = bbo_pkg::CSR_DATA_W'(width_ff);
         bbo_pkg::REG_IMAGE_HEIGHT: csr_prdata = bbo_pkg::CSR_DATA_W'(height_ff);
         bbo_pkg::REG_COLOR_R:      csr_prdata = bbo_pkg::CSR_DATA_W'(color_r_ff);
         bbo_pkg::REG_COLOR_G:      csr_prdata = bbo_pkg::CSR_DATA_W'(color_g_ff);
         bbo_pkg::REG_COLOR_B:      csr_prdata = bbo_pkg::CSR_DATA_W'(color_b_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // pipeline control
   logic        s1_valid_ff, s1_valid_in;
   logic        s2_valid_ff, s2_valid_in;
   logic        s3_valid_ff, s3_valid_in;
   s1_item_type s1_ff, s1_in;
   s2_item_type s2_ff, s2_in;
   s3_item_type s3_ff, s3_in;
   logic        s1_ready, s2_ready, s3_ready;
   logic        s1_adv, s2_adv, accept, known_kind, s2_pixel;

   assign s2_pixel   = (s2_ff.kind == bbo_pkg::KIND_PIXEL);
   assign s3_ready   = !s3_valid_ff || rsp.ready;
   // clear and load items retire in stage two without a result
   assign s2_adv     = s2_valid_ff && (!s2_pixel || s3_ready);
   assign s2_ready   = !s2_valid_ff || s2_adv;
   assign s1_adv     = s1_valid_ff && s2_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign accept     = req.valid && s1_ready;
   assign req.ready  = s1_ready;
   assign known_kind = (req.kind == bbo_pkg::KIND_CLEAR) ||
                       (req.kind == bbo_pkg::KIND_LOAD) ||
                       (req.kind == bbo_pkg::KIND_PIXEL);

   // stage one: take the item, drop the unused kind
   always_comb begin
      s1_valid_in = s1_ready ? (accept && known_kind) : s1_valid_ff;
      s1_in       = s1_ff;
      if (accept) begin
         s1_in.kind   = req.kind;
         s1_in.slot   = req.box_index;
         s1_in.left   = req.box_left;
         s1_in.top    = req.box_top;
         s1_in.right  = req.box_right;
         s1_in.bottom = req.box_bottom;
         s1_in.x      = req.pixel_x;
         s1_in.y      = req.pixel_y;
         s1_in.r      = req.in_r;
         s1_in.g      = req.in_g;
         s1_in.b      = req.in_b;
      end
   end

   // stage one work: clamp corners, check pixel against the image size
   always_comb begin
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
      s2_in       = s2_ff;
      if (s1_adv) begin
         s2_in.kind     = s1_ff.kind;
         s2_in.slot     = s1_ff.slot;
         s2_in.x0       = clamp_coord(bbo_pkg::bnd_type'(s1_ff.left), width_ff);
         s2_in.y0       = clamp_coord(bbo_pkg::bnd_type'(s1_ff.top), height_ff);
         s2_in.x1       = clamp_coord(bbo_pkg::bnd_type'(s1_ff.right) -
                                      bbo_pkg::bnd_type'(1), width_ff);
         s2_in.y1       = clamp_coord(bbo_pkg::bnd_type'(s1_ff.bottom) -
                                      bbo_pkg::bnd_type'(1), height_ff);
         s2_in.x        = s1_ff.x;
         s2_in.y        = s1_ff.y;
         s2_in.in_image = (bbo_pkg::DIM_W'(s1_ff.x) < width_ff) &&
                          (bbo_pkg::DIM_W'(s1_ff.y) < height_ff);
         s2_in.r        = s1_ff.r;
         s2_in.g        = s1_ff.g;
         s2_in.b        = s1_ff.b;
      end
   end

   // stage two work: table write or parallel border test
   bbo_pkg::bounds_type   wr_bounds;
   bbo_pkg::bnd_type      pix_x, pix_y;
   bbo_pkg::lane_ctl_type lane_ctl [MAX_BOXES];
   logic [MAX_BOXES-1:0]  lane_hit;
   logic                  border;

   always_comb begin
      wr_bounds.x0       = s2_ff.x0;
      wr_bounds.x0_end   = s2_ff.x0 + bbo_pkg::bnd_type'(BAND_W);
      wr_bounds.x1_start = s2_ff.x1 - bbo_pkg::bnd_type'(BAND_W);
      wr_bounds.x1       = s2_ff.x1;
      wr_bounds.y0       = s2_ff.y0;
      wr_bounds.y0_end   = s2_ff.y0 + bbo_pkg::bnd_type'(BAND_W);
      wr_bounds.y1_start = s2_ff.y1 - bbo_pkg::bnd_type'(BAND_W);
      wr_bounds.y1       = s2_ff.y1;
      pix_x              = bbo_pkg::bnd_type'(s2_ff.x);
      pix_y              = bbo_pkg::bnd_type'(s2_ff.y);
   end

   for (genvar i = 0; i < MAX_BOXES; i++) begin : g_lane
      // a slot past MAX_BOXES matches no lane, so its load is dropped
      assign lane_ctl[i].clear = s2_adv && (s2_ff.kind == bbo_pkg::KIND_CLEAR);
      assign lane_ctl[i].load  = s2_adv && (s2_ff.kind == bbo_pkg::KIND_LOAD) &&
                                 (32'(s2_ff.slot) == 32'(i));

      bbo_box_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl       (lane_ctl[i]),
         .wr_bounds (wr_bounds),
         .pix_x     (pix_x),
         .pix_y     (pix_y),
         .hit       (lane_hit[i])
      );
   end

   assign border = s2_ff.in_image && (|lane_hit);

   always_comb begin
      s3_valid_in = s3_ready ? (s2_adv && s2_pixel) : s3_valid_ff;
      s3_in       = s3_ff;
      if (s3_ready && s2_adv && s2_pixel) begin
         s3_in.on_border = border;
         s3_in.r         = border ? color_r_ff : s2_ff.r;
         s3_in.g         = border ? color_g_ff : s2_ff.g;
         s3_in.b         = border ? color_b_ff : s2_ff.b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
   end

   assign rsp.valid     = s3_valid_ff;
   assign rsp.out_r     = s3_ff.r;
   assign rsp.out_g     = s3_ff.g;
   assign rsp.out_b     = s3_ff.b;
   assign rsp.on_border = s3_ff.on_border;

endmodule

// ===== design/bbo_checker.sv =====
// ----------------------------------------------------------------------------
// bbo_checker
// Port-level checks of the box overlay, bound to the top level.
// ----------------------------------------------------------------------------
module bbo_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [bbo_pkg::COLOR_W-1:0]    rsp_out_r,
   input logic [bbo_pkg::COLOR_W-1:0]    rsp_out_g,
   input logic [bbo_pkg::COLOR_W-1:0]    rsp_out_b,
   input logic                           rsp_on_border,
   input logic                           csr_psel,
   input logic                           csr_penable,
   input logic                           csr_pwrite,
   input logic [bbo_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [bbo_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input logic [bbo_pkg::CSR_DATA_W-1:0] csr_prdata
);

   logic [bbo_pkg::CSR_ADDR_W-1:0] color_r_addr;
   logic                           seen_item_ff, seen_item_in;

   assign color_r_addr = {bbo_pkg::REG_COLOR_R, 2'b00};
   assign seen_item_in = seen_item_ff || (req_valid && req_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_item_ff <= 1'b0;
      end else begin
         seen_item_ff <= seen_item_in;
      end
   end

   // hold a stalled result
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_out_r, rsp_out_g, rsp_out_b, rsp_on_border}))
      else $error("stalled result changed or vanished");

   // input backpressure only when the pipeline is full behind a stalled result
   a_ready_only_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while the result side is free");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   a_color_readback : assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_paddr == color_r_addr ##1
       csr_psel && !csr_pwrite && csr_paddr == color_r_addr)
      |-> csr_prdata[bbo_pkg::COLOR_W-1:0] == $past(csr_pwdata[bbo_pkg::COLOR_W-1:0]))
      else $error("border red register does not read back");

   // a result needs at least one item taken since reset
   a_no_result_from_nothing : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> seen_item_ff)
      else $error("result appeared without an item");

endmodule

bind bounding_box_border_overlay_core bbo_checker u_bbo_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_out_r     (rsp.out_r),
   .rsp_out_g     (rsp.out_g),
   .rsp_out_b     (rsp.out_b),
   .rsp_on_border (rsp.on_border),
   .csr_psel      (csr_psel),
   .csr_penable   (csr_penable),
   .csr_pwrite    (csr_pwrite),
   .csr_paddr     (csr_paddr),
   .csr_pwdata    (csr_pwdata),
   .csr_prdata    (csr_prdata)
);

// ===== verif/bounding_box_border_overlay_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounding_box_border_overlay_core_test
// Self-checking bench for the box outline overlay: it loads box tables,
// streams pixels around the box edges, predicts every outgoing pixel and
// compares it field by field while both channels stall at random.
// ----------------------------------------------------------------------------
module bounding_box_border_overlay_core_test;

   localparam int                         NUM_SLOTS   = bbo_pkg::MAX_BOXES_DEFAULT;
   localparam int                         BAND        = bbo_pkg::BAND_W_DEFAULT;
   localparam logic [bbo_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int                         PIX_MAX     = (1 << bbo_pkg::PIX_W) - 1;

   typedef struct {
      logic [bbo_pkg::KIND_W-1:0]          kind;
      logic [bbo_pkg::SLOT_W-1:0]          slot;
      logic signed [bbo_pkg::CORNER_W-1:0] left;
      logic signed [bbo_pkg::CORNER_W-1:0] top;
      logic signed [bbo_pkg::CORNER_W-1:0] right;
      logic signed [bbo_pkg::CORNER_W-1:0] bottom;
      logic [bbo_pkg::PIX_W-1:0]           x;
      logic [bbo_pkg::PIX_W-1:0]           y;
      logic [bbo_pkg::COLOR_W-1:0]         r;
      logic [bbo_pkg::COLOR_W-1:0]         g;
      logic [bbo_pkg::COLOR_W-1:0]         b;
   } overlay_item_type;

   typedef struct {
      logic [bbo_pkg::COLOR_W-1:0] r;
      logic [bbo_pkg::COLOR_W-1:0] g;
      logic [bbo_pkg::COLOR_W-1:0] b;
      logic                        on_border;
   } pixel_result_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [bbo_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [bbo_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [bbo_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   bbo_req_if req_ch ();
   bbo_rsp_if rsp_ch ();

   bounding_box_border_overlay_core dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // overlay state as the block should hold it
   int unsigned                 img_w;
   int unsigned                 img_h;
   logic [bbo_pkg::COLOR_W-1:0] paint_r;
   logic [bbo_pkg::COLOR_W-1:0] paint_g;
   logic [bbo_pkg::COLOR_W-1:0] paint_b;
   int                          box_x0 [NUM_SLOTS];
   int                          box_y0 [NUM_SLOTS];
   int                          box_x1 [NUM_SLOTS];
   int                          box_y1 [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]        box_live;

   pixel_result_type pending_pixels [$];
   int               mismatches  = 0;
   int               items_sent  = 0;
   bit               src_idle_on = 1'b0;
   bit               snk_idle_on = 1'b0;

   function automatic int clamp_corner(int v, int unsigned limit);
      int hi;
      hi = int'(limit) - 1;
      if (v > hi) v = hi;
      if (v < 0) v = 0;
      return v;
   endfunction

   function automatic bit in_span(int v, int lo, int hi);
      return v >= lo && v < hi;
   endfunction

   function automatic bit hits_box(int i, int x, int y);
      bit rows;
      bit cols;
      rows = in_span(y, box_y0[i], box_y1[i]);
      cols = in_span(x, box_x0[i], box_x1[i]);
      return (rows && in_span(x, box_x0[i], box_x0[i] + BAND))
          || (rows && in_span(x, box_x1[i] - BAND, box_x1[i]))
          || (cols && in_span(y, box_y0[i], box_y0[i] + BAND))
          || (cols && in_span(y, box_y1[i] - BAND, box_y1[i]));
   endfunction

   function automatic pixel_result_type paint_pixel(overlay_item_type it);
      pixel_result_type res;
      bit               hit;
      int               x;
      int               y;
      x   = int'(it.x);
      y   = int'(it.y);
      hit = 1'b0;
      // pixels beyond the image edge are never painted
      if (x < int'(img_w) && y < int'(img_h))
         for (int i = 0; i < NUM_SLOTS; i++)
            if (box_live[i] && hits_box(i, x, y)) hit = 1'b1;
      if (hit) begin
         res.r = paint_r;
         res.g = paint_g;
         res.b = paint_b;
      end else begin
         res.r = it.r;
         res.g = it.g;
         res.b = it.b;
      end
      res.on_border = hit;
      return res;
   endfunction

   task automatic apply_item(overlay_item_type it);
      int s;
      case (it.kind)
         bbo_pkg::KIND_CLEAR: box_live = '0;
         bbo_pkg::KIND_LOAD: begin
            s = int'(it.slot);
            if (s < NUM_SLOTS) begin
               box_x0[s] = clamp_corner(int'(it.left), img_w);
               box_y0[s] = clamp_corner(int'(it.top), img_h);
               box_x1[s] = clamp_corner(int'(it.right) - 1, img_w);
               box_y1[s] = clamp_corner(int'(it.bottom) - 1, img_h);
               box_live[s] = 1'b1;
            end
         end
         bbo_pkg::KIND_PIXEL: pending_pixels.push_back(paint_pixel(it));
         default: ;
      endcase
   endtask

   task automatic note_mismatch(string what, int want, int got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %0d, got %0d", what, want, got);
   endtask

   // result side: compare each taken pixel with the oldest prediction
   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_pixels.size() == 0) begin
            note_mismatch("unexpected pixel, pending count", 0, 1);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_ch.out_r !== want.r)
               note_mismatch("out_r", int'(want.r), int'(rsp_ch.out_r));
            if (rsp_ch.out_g !== want.g)
               note_mismatch("out_g", int'(want.g), int'(rsp_ch.out_g));
            if (rsp_ch.out_b !== want.b)
               note_mismatch("out_b", int'(want.b), int'(rsp_ch.out_b));
            if (rsp_ch.on_border !== want.on_border)
               note_mismatch("on_border", int'(want.on_border), int'(rsp_ch.on_border));
         end
      end
   end

   // result side stalls
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         gap = snk_idle_on ? int'($urandom_range(0, 7)) : 0;
         if (gap != 0) begin
            rsp_ch.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready));
      end
   end

   task automatic send_item(overlay_item_type it);
      int gap;
      gap = src_idle_on ? int'($urandom_range(0, 7)) : 0;
      if (gap != 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.kind       = it.kind;
      req_ch.box_index  = it.slot;
      req_ch.box_left   = it.left;
      req_ch.box_top    = it.top;
      req_ch.box_right  = it.right;
      req_ch.box_bottom = it.bottom;
      req_ch.pixel_x    = it.x;
      req_ch.pixel_y    = it.y;
      req_ch.in_r       = it.r;
      req_ch.in_g       = it.g;
      req_ch.in_b       = it.b;
      req_ch.valid      = 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      apply_item(it);
      items_sent++;
      @(negedge clock);
   endtask

   // hold the input until every pixel is out, then let the load pipeline empty
   task automatic wait_drain();
      req_ch.valid = 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [bbo_pkg::REG_IDX_W-1:0] idx,
                            logic [bbo_pkg::CSR_DATA_W-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      case (idx)
         bbo_pkg::REG_IMAGE_WIDTH:  img_w   = 32'(value[bbo_pkg::DIM_W-1:0]);
         bbo_pkg::REG_IMAGE_HEIGHT: img_h   = 32'(value[bbo_pkg::DIM_W-1:0]);
         bbo_pkg::REG_COLOR_R:      paint_r = value[bbo_pkg::COLOR_W-1:0];
         bbo_pkg::REG_COLOR_G:      paint_g = value[bbo_pkg::COLOR_W-1:0];
         bbo_pkg::REG_COLOR_B:      paint_b = value[bbo_pkg::COLOR_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      // read back the same register
      csr_pwrite  = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata !== value)
         note_mismatch("register readback", int'(value), int'(csr_prdata));
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic set_image(int unsigned w, int unsigned h,
                            logic [7:0] r, logic [7:0] g, logic [7:0] b);
      csr_write(bbo_pkg::REG_IMAGE_WIDTH, w);
      csr_write(bbo_pkg::REG_IMAGE_HEIGHT, h);
      csr_write(bbo_pkg::REG_COLOR_R, 32'(r));
      csr_write(bbo_pkg::REG_COLOR_G, 32'(g));
      csr_write(bbo_pkg::REG_COLOR_B, 32'(b));
   endtask

   // every field random, so unused fields toggle too
   function automatic overlay_item_type noise_item();
      overlay_item_type it;
      it.kind   = bbo_pkg::KIND_W'($urandom_range(0, 3));
      it.slot   = bbo_pkg::SLOT_W'($urandom_range(0, 15));
      it.left   = bbo_pkg::CORNER_W'($urandom_range(0, 8191));
      it.top    = bbo_pkg::CORNER_W'($urandom_range(0, 8191));
      it.right  = bbo_pkg::CORNER_W'($urandom_range(0, 8191));
      it.bottom = bbo_pkg::CORNER_W'($urandom_range(0, 8191));
      it.x      = bbo_pkg::PIX_W'($urandom_range(0, PIX_MAX));
      it.y      = bbo_pkg::PIX_W'($urandom_range(0, PIX_MAX));
      it.r      = bbo_pkg::COLOR_W'($urandom_range(0, 255));
      it.g      = bbo_pkg::COLOR_W'($urandom_range(0, 255));
      it.b      = bbo_pkg::COLOR_W'($urandom_range(0, 255));
      return it;
   endfunction

   function automatic overlay_item_type ctl_item(logic [bbo_pkg::KIND_W-1:0] kind);
      overlay_item_type it;
      it      = noise_item();
      it.kind = kind;
      return it;
   endfunction

   function automatic overlay_item_type load_item(int slot, int l, int t, int r, int b);
      overlay_item_type it;
      it        = noise_item();
      it.kind   = bbo_pkg::KIND_LOAD;
      it.slot   = bbo_pkg::SLOT_W'(slot);
      it.left   = bbo_pkg::CORNER_W'(l);
      it.top    = bbo_pkg::CORNER_W'(t);
      it.right  = bbo_pkg::CORNER_W'(r);
      it.bottom = bbo_pkg::CORNER_W'(b);
      return it;
   endfunction

   function automatic overlay_item_type pixel_item(int x, int y);
      overlay_item_type it;
      it      = noise_item();
      it.kind = bbo_pkg::KIND_PIXEL;
      it.x    = bbo_pkg::PIX_W'(x);
      it.y    = bbo_pkg::PIX_W'(y);
      return it;
   endfunction

   task automatic test_passthrough();
      send_item(pixel_item(5, 5));
      send_item(pixel_item(PIX_MAX, PIX_MAX));
   endtask

   task automatic test_border_bands();
      send_item(load_item(0, 10, 10, 20, 20));
      send_item(pixel_item(10, 12));   // left band
      send_item(pixel_item(18, 12));   // right band
      send_item(pixel_item(19, 12));   // right column is exclusive
      send_item(pixel_item(12, 10));   // top band
      send_item(pixel_item(12, 17));   // bottom band
      send_item(pixel_item(12, 12));   // interior
   endtask

   task automatic test_clamp_and_ignore();
      send_item(load_item(15, -4096, -4096, 4095, 4095));
      send_item(pixel_item(0, 0));
      send_item(pixel_item(639, 100));
      send_item(pixel_item(100, 478));
      send_item(ctl_item(KIND_UNUSED));
      send_item(load_item(3, 50, 50, 45, 45));    // inverted box
      send_item(pixel_item(50, 50));
      send_item(ctl_item(bbo_pkg::KIND_CLEAR));
      send_item(pixel_item(0, 0));
   endtask

   task automatic test_register_extremes();
      wait_drain();
      set_image(0, 0, 8'h00, 8'h00, 8'h00);
      send_item(load_item(1, 0, 0, 10, 10));
      send_item(pixel_item(0, 0));
      wait_drain();
      set_image(8191, 8191, 8'hff, 8'hff, 8'hff);
      send_item(load_item(2, -4096, -4096, 4095, 4095));
      send_item(pixel_item(4093, 100));
      send_item(pixel_item(PIX_MAX, PIX_MAX));
      send_item(pixel_item(4093, 0));
      wait_drain();
      set_image(1, 1, 8'h5a, 8'ha5, 8'h3c);
      send_item(load_item(4, 0, 0, 5, 5));
      send_item(pixel_item(0, 0));
      send_item(pixel_item(1, 0));
   endtask

   function automatic int pick_dim();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return int'($urandom_range(8, 80));
         6: return 640;
         7: return 4096;
         8: return int'($urandom_range(1, 4096));
         default: begin
            case ($urandom_range(0, 2))
               0: return 0;
               1: return 1;
               default: return 8191;
            endcase
         end
      endcase
   endfunction

   function automatic int clip_pix(int v);
      if (v < 0) return 0;
      if (v > PIX_MAX) return PIX_MAX;
      return v;
   endfunction

   function automatic int near_edge(int c);
      return clip_pix(c + int'($urandom_range(0, 6)) - 3);
   endfunction

   // a point from two before a to two past b, with a <= b
   function automatic int across(int a, int b);
      return clip_pix(a - 2 + int'($urandom_range(0, b - a + 4)));
   endfunction

   function automatic int in_image(int unsigned dim);
      int top;
      top = (dim > PIX_MAX) ? PIX_MAX : int'(dim) + 2;
      return clip_pix(int'($urandom_range(0, top)));
   endfunction

   function automatic overlay_item_type random_box(int unsigned w, int unsigned h);
      int l;
      int t;
      if ($urandom_range(0, 9) == 0)
         return ctl_item(bbo_pkg::KIND_LOAD);   // wild corners
      l = in_image(w) - 4;
      t = in_image(h) - 4;
      if ($urandom_range(0, 9) == 0)
         return load_item(int'($urandom_range(0, 15)), l, t,
                          l - int'($urandom_range(0, 10)),
                          t - int'($urandom_range(0, 10)));
      return load_item(int'($urandom_range(0, 15)), l, t,
                       l + int'($urandom_range(0, 40)),
                       t + int'($urandom_range(0, 40)));
   endfunction

   function automatic overlay_item_type random_pixel();
      int s;
      int x;
      int y;
      int lo;
      int hi;
      int pick;
      pick = int'($urandom_range(0, 9));
      if (pick == 0 || box_live == '0)
         return pixel_item(int'($urandom_range(0, PIX_MAX)),
                           int'($urandom_range(0, PIX_MAX)));
      if (pick <= 2)
         return pixel_item(in_image(img_w), in_image(img_h));
      do s = int'($urandom_range(0, NUM_SLOTS - 1)); while (!box_live[s]);
      lo = (box_x0[s] < box_x1[s]) ? box_x0[s] : box_x1[s];
      hi = (box_x0[s] < box_x1[s]) ? box_x1[s] : box_x0[s];
      case ($urandom_range(0, 2))
         0: x = near_edge(box_x0[s]);
         1: x = near_edge(box_x1[s]);
         default: x = across(lo, hi);
      endcase
      lo = (box_y0[s] < box_y1[s]) ? box_y0[s] : box_y1[s];
      hi = (box_y0[s] < box_y1[s]) ? box_y1[s] : box_y0[s];
      case ($urandom_range(0, 2))
         0: y = near_edge(box_y0[s]);
         1: y = near_edge(box_y1[s]);
         default: y = across(lo, hi);
      endcase
      return pixel_item(x, y);
   endfunction

   // phases: new settings, optional clear, a few boxes, then a scan of pixels
   task automatic test_random_scenes();
      int loads;
      int pixels;
      int pick;
      while (items_sent < 2000) begin
         wait_drain();
         set_image(pick_dim(), pick_dim(), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         src_idle_on = ($urandom_range(0, 3) != 0);
         snk_idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 1) == 1) send_item(ctl_item(bbo_pkg::KIND_CLEAR));
         loads = int'($urandom_range(1, 6));
         repeat (loads) send_item(random_box(img_w, img_h));
         pixels = int'($urandom_range(30, 80));
         repeat (pixels) begin
            pick = int'($urandom_range(0, 39));
            if (pick == 0)
               send_item(ctl_item(KIND_UNUSED));
            else if (pick == 1)
               send_item(random_box(img_w, img_h));
            else if (pick == 2)
               send_item(ctl_item(bbo_pkg::KIND_CLEAR));
            else
               send_item(random_pixel());
         end
      end
   endtask

   initial begin
      img_w        = 32'(bbo_pkg::IMAGE_WIDTH_RST);
      img_h        = 32'(bbo_pkg::IMAGE_HEIGHT_RST);
      paint_r      = bbo_pkg::COLOR_R_RST;
      paint_g      = bbo_pkg::COLOR_G_RST;
      paint_b      = bbo_pkg::COLOR_B_RST;
      box_live     = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         box_x0[i] = 0;
         box_y0[i] = 0;
         box_x1[i] = 0;
         box_y1[i] = 0;
      end
      reset             = 1'b1;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      req_ch.valid      = 1'b0;
      req_ch.kind       = bbo_pkg::KIND_CLEAR;
      req_ch.box_index  = '0;
      req_ch.box_left   = '0;
      req_ch.box_top    = '0;
      req_ch.box_right  = '0;
      req_ch.box_bottom = '0;
      req_ch.pixel_x    = '0;
      req_ch.pixel_y    = '0;
      req_ch.in_r       = '0;
      req_ch.in_g       = '0;
      req_ch.in_b       = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_passthrough();
      snk_idle_on = 1'b1;
      test_border_bands();
      src_idle_on = 1'b1;
      test_clamp_and_ignore();
      test_register_extremes();
      test_random_scenes();

      wait_drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
